// File: rtl/grammar_notation_lexer_assert.svh
// ----------------------------------------------------------------------------
// grammar_notation_lexer_assert
// Assertion macros of the grammar notation lexer, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef GRAMMAR_NOTATION_LEXER_ASSERT_SVH
`define GRAMMAR_NOTATION_LEXER_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define GNL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define GNL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define GNL_ASSERT(label, clk, rst, prop, msg)
`define GNL_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/gnl_pkg.sv
// ----------------------------------------------------------------------------
// gnl_pkg
// Types, token codes and character constants of the grammar notation lexer.
// ----------------------------------------------------------------------------
package gnl_pkg;

   // width of the running character position
   localparam int POSITION_BITS = 16;
   localparam int CHAR_BITS     = 8;
   localparam int KIND_BITS     = 4;
   localparam int FIELD_BITS    = 16;

   localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // token kinds
   typedef enum logic [KIND_BITS-1:0] {
      KIND_LPAREN      = 4'd0,
      KIND_RPAREN      = 4'd1,
      KIND_EQUALS      = 4'd2,
      KIND_BAR         = 4'd3,
      KIND_STAR        = 4'd4,
      KIND_PLUS        = 4'd5,
      KIND_QUESTION    = 4'd6,
      KIND_BANG        = 4'd7,
      KIND_DOT         = 4'd8,
      KIND_END         = 4'd9,
      KIND_NEWLINE     = 4'd10,
      KIND_EXACT       = 4'd11,
      KIND_UNION       = 4'd12,
      KIND_TERMINAL    = 4'd13,
      KIND_NONTERMINAL = 4'd14,
      KIND_ERROR       = 4'd15
   } kind_type;

   // character codes
   localparam logic [CHAR_BITS-1:0] CHAR_NUL       = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_BANG      = 8'h21;
   localparam logic [CHAR_BITS-1:0] CHAR_QUOTE     = 8'h22;
   localparam logic [CHAR_BITS-1:0] CHAR_APOS      = 8'h27;
   localparam logic [CHAR_BITS-1:0] CHAR_LPAREN    = 8'h28;
   localparam logic [CHAR_BITS-1:0] CHAR_RPAREN    = 8'h29;
   localparam logic [CHAR_BITS-1:0] CHAR_STAR      = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS      = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT       = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [CHAR_BITS-1:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [CHAR_BITS-1:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [CHAR_BITS-1:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CHAR_BAR       = 8'h7C;

   // one result token
   typedef struct packed {
      kind_type              kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic                  last;
   } token_type;

   // clamp a position-sized value to the output field
   function automatic logic [FIELD_BITS-1:0] sat_field(input logic [POSITION_BITS:0] value);
      logic [63:0] wide;
      wide = 64'(value);
      if (wide > 64'(FIELD_MAX)) begin
         return FIELD_MAX;
      end
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

// File: rtl/gnl_req_if.sv
// ----------------------------------------------------------------------------
// gnl_req_if
// Request channel of the lexer: one character of text per request.
// ----------------------------------------------------------------------------
interface gnl_req_if
   import gnl_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// File: rtl/gnl_rsp_if.sv
// ----------------------------------------------------------------------------
// gnl_rsp_if
// Response channel of the lexer: one token per handshake, up to two for
// each request.
// ----------------------------------------------------------------------------
interface gnl_rsp_if
   import gnl_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  token_kind;
   logic [FIELD_BITS-1:0] token_start;
   logic [FIELD_BITS-1:0] token_length;
   logic                  last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input last_of_run, output ready);
endinterface

// File: rtl/grammar_notation_lexer.sv
// ----------------------------------------------------------------------------
// grammar_notation_lexer
// Character-at-a-time tokenizer for a small grammar notation.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one text byte per request (0 marks end of text).
//   rsp_chan carries tokens: kind, start position, length and a flag on
//   the last token that a character caused (a character causes 0, 1 or 2).
//   A character is taken into an input register, decoded from it against
//   the scan state, and its tokens are written into a four-entry output
//   queue. Throughput is one character per cycle while each character yields
//   at most one token and rsp_chan.ready stays high; a character that closes
//   an identifier and also emits its own token yields two tokens, each in its
//   own response handshake. The rate is set by the output queue port, which
//   delivers one token per cycle while rsp_chan.ready is high. The decode
//   advances only while the queue has room for two tokens, so a stalled
//   receiver lets the queue fill up, then drops req_chan.ready.
//   After an error, an end of text or an unterminated span the lexer halts:
//   requests are still taken but yield no tokens until reset.
//   Reset (synchronous, active high) empties the queue and the input
//   register and returns to idle scanning at position zero.
// ----------------------------------------------------------------------------
module grammar_notation_lexer
   import gnl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gnl_req_if.sink    req_chan,
   gnl_rsp_if.source  rsp_chan
);

`include "grammar_notation_lexer_assert.svh"

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] ROOM_LIMIT = COUNT_BITS'(QUEUE_DEPTH - 2);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_EXACT,
      MODE_UNION,
      MODE_APOS,
      MODE_UPPER,
      MODE_LOWER
   } mode_type;

   // registers
   logic                     in_valid_ff;
   logic [CHAR_BITS-1:0]     in_char_ff;
   mode_type                 mode_ff, mode_in;
   logic                     halted_ff, halted_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] span_ff, span_in;
   token_type                queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;

   // decode results
   logic                     advance;
   logic                     pop;
   logic                     has_a, has_b;
   token_type                tok_a, tok_b;
   token_type                first_tok, second_tok;
   logic [1:0]               push_n;
   logic                     do_idle;
   logic [CHAR_BITS-1:0]     ch;
   logic [POSITION_BITS:0]   span_len;
   logic [CHAR_BITS-1:0]     closer;
   kind_type                 span_kind;
   logic                     run_match;
   kind_type                 run_kind;

   // punctuation that becomes a one-character token
   function automatic logic punct_hit(input logic [CHAR_BITS-1:0] c, output kind_type k);
      punct_hit = 1'b1;
      k = KIND_LPAREN;
      case (c)
         CHAR_LPAREN:   k = KIND_LPAREN;
         CHAR_RPAREN:   k = KIND_RPAREN;
         CHAR_EQUALS:   k = KIND_EQUALS;
         CHAR_BAR:      k = KIND_BAR;
         CHAR_STAR:     k = KIND_STAR;
         CHAR_PLUS:     k = KIND_PLUS;
         CHAR_QUESTION: k = KIND_QUESTION;
         CHAR_BANG:     k = KIND_BANG;
         CHAR_DOT:      k = KIND_DOT;
         CHAR_NEWLINE:  k = KIND_NEWLINE;
         default:       punct_hit = 1'b0;
      endcase
   endfunction

   // handshake: the input register moves on when the queue holds room for two
   assign advance        = in_valid_ff && (count_ff <= ROOM_LIMIT);
   assign req_chan.ready = !in_valid_ff || advance;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   assign ch       = in_char_ff;
   assign span_len = {1'b0, pos_ff} - {1'b0, span_ff} + (POSITION_BITS+1)'(1);

   // scan state update and token generation
   always_comb begin
      kind_type pk;
      logic     is_punct;
      mode_in   = mode_ff;
      halted_in = halted_ff;
      span_in   = span_ff;
      has_a     = 1'b0;
      has_b     = 1'b0;
      tok_a     = '0;
      tok_b     = '0;
      do_idle   = 1'b0;
      closer    = CHAR_QUOTE;
      span_kind = KIND_EXACT;
      run_match = 1'b0;
      run_kind  = KIND_TERMINAL;

      case (mode_ff)
         MODE_COMMENT: begin
            if (ch == CHAR_NEWLINE) begin
               mode_in = MODE_IDLE;
            end else if (ch == CHAR_NUL) begin
               has_a        = 1'b1;
               tok_a.kind   = KIND_END;
               tok_a.start  = sat_field({1'b0, pos_ff});
               tok_a.length = '0;
               halted_in    = 1'b1;
            end
         end
         MODE_EXACT, MODE_UNION, MODE_APOS: begin
            if (mode_ff == MODE_UNION) begin
               closer    = CHAR_RBRACKET;
               span_kind = KIND_UNION;
            end else if (mode_ff == MODE_APOS) begin
               closer    = CHAR_APOS;
               span_kind = KIND_TERMINAL;
            end
            if (ch == closer) begin
               has_a        = 1'b1;
               tok_a.kind   = span_kind;
               tok_a.start  = sat_field({1'b0, span_ff});
               tok_a.length = sat_field(span_len);
               mode_in      = MODE_IDLE;
            end else if (ch == CHAR_NUL) begin
               has_a        = 1'b1;
               tok_a.kind   = KIND_ERROR;
               tok_a.start  = sat_field({1'b0, span_ff});
               tok_a.length = sat_field(span_len);
               halted_in    = 1'b1;
            end
         end
         MODE_UPPER, MODE_LOWER: begin
            if (mode_ff == MODE_UPPER) begin
               run_match = ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
               run_kind  = KIND_TERMINAL;
            end else begin
               run_match = ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
               run_kind  = KIND_NONTERMINAL;
            end
            // the ender closes the run, then is scanned as between tokens
            if (!run_match) begin
               has_a        = 1'b1;
               tok_a.kind   = run_kind;
               tok_a.start  = sat_field({1'b0, span_ff});
               tok_a.length = sat_field(span_len - (POSITION_BITS+1)'(1));
               mode_in      = MODE_IDLE;
               do_idle      = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            do_idle = 1'b1;
         end
      endcase

      // scanning between tokens
      is_punct = punct_hit(ch, pk);
      if (do_idle) begin
         if (is_punct) begin
            has_b        = 1'b1;
            tok_b.kind   = pk;
            tok_b.start  = sat_field({1'b0, pos_ff});
            tok_b.length = FIELD_BITS'(1);
         end else if (ch == CHAR_NUL) begin
            has_b        = 1'b1;
            tok_b.kind   = KIND_END;
            tok_b.start  = sat_field({1'b0, pos_ff});
            tok_b.length = '0;
            halted_in    = 1'b1;
         end else if (!(ch inside {CHAR_SPACE, CHAR_TAB})) begin
            span_in = pos_ff;
            if (ch == CHAR_SEMICOLON) begin
               mode_in = MODE_COMMENT;
            end else if (ch == CHAR_QUOTE) begin
               mode_in = MODE_EXACT;
            end else if (ch == CHAR_LBRACKET) begin
               mode_in = MODE_UNION;
            end else if (ch == CHAR_APOS) begin
               mode_in = MODE_APOS;
            end else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
               mode_in = MODE_UPPER;
            end else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
               mode_in = MODE_LOWER;
            end else begin
               has_b        = 1'b1;
               tok_b.kind   = KIND_ERROR;
               tok_b.start  = sat_field({1'b0, pos_ff});
               tok_b.length = FIELD_BITS'(1);
               halted_in    = 1'b1;
            end
         end
      end

      // a stalled or halted lexer keeps its scan state and emits nothing; a halted one swallows requests without effect
      if (!advance || halted_ff) begin
         mode_in   = mode_ff;
         halted_in = halted_ff;
         span_in   = span_ff;
         has_a     = 1'b0;
         has_b     = 1'b0;
      end
   end

   // pack the tokens of this character in order and flag the last one
   always_comb begin
      first_tok  = has_a ? tok_a : tok_b;
      second_tok = tok_b;
      push_n     = {1'b0, has_a} + {1'b0, has_b};
      first_tok.last  = (push_n == 2'd1);
      second_tok.last = 1'b1;
   end

   // position and queue bookkeeping
   always_comb begin
      pos_in = pos_ff;
      if (advance && !halted_ff && (pos_ff != POS_MAX)) begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + COUNT_BITS'(push_n) - COUNT_BITS'(pop);
   end

   // state, input register and output queue
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         halted_ff   <= 1'b0;
         pos_ff      <= '0;
         span_ff     <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         mode_ff   <= mode_in;
         halted_ff <= halted_in;
         pos_ff    <= pos_in;
         span_ff   <= span_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_char_ff <= req_chan.char_code;
      end
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_tok;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_BITS'(1)] <= second_tok;
      end
   end

   // response channel
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.token_kind   = queue_ff[rd_ptr_ff].kind;
   assign rsp_chan.token_start  = queue_ff[rd_ptr_ff].start;
   assign rsp_chan.token_length = queue_ff[rd_ptr_ff].length;
   assign rsp_chan.last_of_run  = queue_ff[rd_ptr_ff].last;

   // checks
   `GNL_ASSERT_ALWAYS(a_queue_bound, clock, reset || (count_ff <= COUNT_BITS'(QUEUE_DEPTH)),
      "output queue overflow")
   `GNL_ASSERT(a_room_on_push, clock, reset, (push_n != 2'd0) |-> (count_ff <= ROOM_LIMIT),
      "tokens pushed without room for two")
   `GNL_ASSERT(a_halt_sticks, clock, reset, halted_ff |=> halted_ff,
      "halt released without reset")
   `GNL_ASSERT(a_halt_silent, clock, reset, halted_ff |-> (push_n == 2'd0),
      "halted lexer produced a token")
   `GNL_ASSERT(a_pos_monotonic, clock, reset, !$past(reset) |-> (pos_ff >= $past(pos_ff)),
      "character position went backward")

endmodule
